### rtl/u8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned CpWidth     = 21;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [CpWidth-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpWidth-1:0] MinLen2     = 21'h000080;
  localparam logic [CpWidth-1:0] MinLen3     = 21'h000800;
  localparam logic [CpWidth-1:0] MinLen4     = 21'h010000;
  // Code points D800-DFFF share these upper bits.
  localparam logic [9:0]         SurrogateHi = 10'h01B;

  typedef enum logic [2:0] {
    KIND_ASCII = 3'd0,
    KIND_CONT  = 3'd1,
    KIND_LEAD2 = 3'd2,
    KIND_LEAD3 = 3'd3,
    KIND_LEAD4 = 3'd4,
    KIND_BAD   = 3'd5
  } byte_kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               is_error;
    logic               stream_end;
  } out_item_t;

  // A byte after classification: its kind and the payload bits it carries.
  typedef struct packed {
    byte_kind_e kind;
    logic [6:0] bits;
    logic       last_byte;
  } cls_item_t;

endpackage

`default_nettype wire

### rtl/utf8_validating_decoder.sv
// A byte goes through the queue entry and then the result register before its result can be popped.
// Throughput: one byte per cycle, set by the back stage; an unpopped result stalls it.
// A two-entry queue sits between byte classification and decoding; full is registered.
// Reset clears the queue, the decoder state and the result slot; no result is waiting after it.
`timescale 1ns / 1ps
`default_nettype none

module utf8_validating_decoder import u8d_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      push,
  output var logic      full,
  input  var in_item_t  in_item_i,
  output var logic      empty,
  input  var logic      pop,
  output var out_item_t out_item_o
);

  cls_item_t cls_in, cls_out;
  logic      q_valid, q_take;

  u8d_front u_front (
    .item_i (in_item_i),
    .cls_o  (cls_in)
  );

  u8d_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (cls_in),
    .full_o    (full),
    .rd_en_i   (q_take),
    .rd_data_o (cls_out),
    .valid_o   (q_valid)
  );

  u8d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (cls_out),
    .take_o  (q_take),
    .empty_o (empty),
    .pop_i   (pop),
    .out_o   (out_item_o)
  );

endmodule

`default_nettype wire

### rtl/u8d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_front import u8d_pkg::*; (
  input  var in_item_t  item_i,
  output var cls_item_t cls_o
);

  logic [7:0] b;

  assign b = item_i.byte_value;

  always_comb begin
    cls_o.last_byte = item_i.last_byte;
    cls_o.bits      = 7'd0;
    if (b[7] == 1'b0) begin
      cls_o.kind = KIND_ASCII;
      cls_o.bits = b[6:0];
    end else if (b[6] == 1'b0) begin
      cls_o.kind = KIND_CONT;
      cls_o.bits = {1'b0, b[5:0]};
    end else if (b[5] == 1'b0) begin
      cls_o.kind = KIND_LEAD2;
      cls_o.bits = {2'b00, b[4:0]};
    end else if (b[4] == 1'b0) begin
      cls_o.kind = KIND_LEAD3;
      cls_o.bits = {3'b000, b[3:0]};
    end else if (b[3] == 1'b0) begin
      cls_o.kind = KIND_LEAD4;
      cls_o.bits = {4'b0000, b[2:0]};
    end else begin
      cls_o.kind = KIND_BAD;
    end
  end

endmodule

`default_nettype wire

### rtl/u8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue import u8d_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      wr_en_i,
  input  var cls_item_t wr_data_i,
  output var logic      full_o,
  input  var logic      rd_en_i,
  output var cls_item_t rd_data_o,
  output var logic      valid_o
);

  cls_item_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;
  logic                   do_wr, do_rd;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/u8d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_back import u8d_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      valid_i,
  input  var cls_item_t item_i,
  output var logic      take_o,
  output var logic      empty_o,
  input  var logic      pop_i,
  output var out_item_t out_o
);

  logic [1:0]         pending_q, pending_d;
  logic [CpWidth-1:0] acc_q, acc_d;
  logic [2:0]         len_q, len_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               bad, done;
  logic [CpWidth-1:0] cp, acc_next, min_cp;
  logic [1:0]         pending_next;

  // The back stage moves whenever the result slot is free or being drained.
  assign take_o  = valid_i && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

  assign acc_next     = {acc_q[CpWidth-7:0], item_i.bits[5:0]};
  assign pending_next = pending_q - 2'd1;

  always_comb begin
    unique case (len_q)
      3'd2:    min_cp = MinLen2;
      3'd3:    min_cp = MinLen3;
      3'd4:    min_cp = MinLen4;
      default: min_cp = '0;
    endcase
  end

  always_comb begin
    pending_d   = pending_q;
    acc_d       = acc_q;
    len_d       = len_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    bad         = 1'b0;
    done        = 1'b0;
    cp          = '0;

    if (take_o) begin
      if (err_q) begin
        // Silent until the end of the text, which reports the error once more.
        if (item_i.last_byte) begin
          bad = 1'b1;
        end
      end else if (pending_q == 2'd0) begin
        unique case (item_i.kind)
          KIND_ASCII: begin
            cp   = {{(CpWidth-7){1'b0}}, item_i.bits};
            done = 1'b1;
          end
          KIND_LEAD2: begin
            acc_d     = {{(CpWidth-7){1'b0}}, item_i.bits};
            pending_d = 2'd1;
            len_d     = 3'd2;
          end
          KIND_LEAD3: begin
            acc_d     = {{(CpWidth-7){1'b0}}, item_i.bits};
            pending_d = 2'd2;
            len_d     = 3'd3;
          end
          KIND_LEAD4: begin
            acc_d     = {{(CpWidth-7){1'b0}}, item_i.bits};
            pending_d = 2'd3;
            len_d     = 3'd4;
          end
          default: bad = 1'b1;
        endcase
      end else if (item_i.kind != KIND_CONT) begin
        bad = 1'b1;
      end else begin
        acc_d     = acc_next;
        pending_d = pending_next;
        if (pending_next == 2'd0) begin
          cp = acc_next;
          if ((acc_next < min_cp) || (acc_next > CpMax) ||
              (acc_next[CpWidth-1:11] == SurrogateHi)) begin
            bad = 1'b1;
          end else begin
            done = 1'b1;
          end
          acc_d = '0;
          len_d = 3'd0;
        end
      end

      if (!bad && !done && item_i.last_byte) begin
        bad = 1'b1;
      end

      if (bad) begin
        pending_d        = 2'd0;
        acc_d            = '0;
        len_d            = 3'd0;
        err_d            = !item_i.last_byte;
        out_valid_d      = 1'b1;
        out_d.code_point = '0;
        out_d.is_error   = 1'b1;
        out_d.stream_end = item_i.last_byte;
      end else if (done) begin
        if (item_i.last_byte) begin
          pending_d = 2'd0;
          acc_d     = '0;
          len_d     = 3'd0;
          err_d     = 1'b0;
        end
        out_valid_d      = 1'b1;
        out_d.code_point = cp;
        out_d.is_error   = 1'b0;
        out_d.stream_end = item_i.last_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 2'd0;
      acc_q       <= '0;
      len_q       <= 3'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire
